// ===== rtl/rrlt_pkg.sv =====
// shared types and codes for the rectangle lock table
package rrlt_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 9;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_NOTLOCKED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BADINDEX  = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
  } rect_t;

  typedef struct packed {
    logic overlap;
    logic equal;
  } cmp_t;

endpackage

// ===== rtl/rrlt_cmp.sv =====
// shared compare unit: overlap and exact match of two rectangles
module rrlt_cmp (
  input  rrlt_pkg::rect_t a_i,
  input  rrlt_pkg::rect_t b_i,
  output rrlt_pkg::cmp_t  res_o
);

  logic signed [rrlt_pkg::CoordW-1:0] max_l, min_r, max_t, min_b;

  always_comb begin
    max_l = (a_i.left > b_i.left) ? a_i.left : b_i.left;
    min_r = (a_i.right < b_i.right) ? a_i.right : b_i.right;
    max_t = (a_i.top > b_i.top) ? a_i.top : b_i.top;
    min_b = (a_i.bottom < b_i.bottom) ? a_i.bottom : b_i.bottom;
    res_o.overlap = (max_l < min_r) && (max_t < min_b);
    res_o.equal   = (a_i == b_i);
  end

endmodule

// ===== rtl/rrlt_store.sv =====
// rectangle storage: one write port, one registered read port
module rrlt_store #(
  parameter int unsigned ENTRIES = rrlt_pkg::EntriesDefault,
  parameter int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  rrlt_pkg::rect_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output rrlt_pkg::rect_t rdata_o
);

  rrlt_pkg::rect_t mem [ENTRIES];
  rrlt_pkg::rect_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rect_region_lock_table.sv =====
// rectangle lock table: acquire, release, clear and read over a held list
// One request is taken when start_i is high and busy_o is low. busy_o is high while a
// request runs past its first cycle and is low again in the cycle its result appears,
// which is for exactly one cycle with done_o high and cannot be stalled (the next
// request may be given in that same cycle). Clear, invalid or out-of-range requests,
// and acquire or release on an empty table finish without leaving idle; a read of a
// held entry passes through a memory read step and an output step. Acquire and release
// walk the held entries through one shared compare unit with one memory read and one
// compare per entry, and an acquire stops at the first overlap or after the last held
// entry; a matching release closes the gap by moving each later entry down one place
// with a read and a write per entry. held_count_o gives the count after the request.
module rect_region_lock_table #(
  parameter int unsigned ENTRIES = rrlt_pkg::EntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic signed [15:0] rect_left_i,
  input  logic signed [15:0] rect_top_i,
  input  logic signed [15:0] rect_right_i,
  input  logic signed [15:0] rect_bottom_i,
  input  logic [7:0]  entry_index_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_top_o,
  output logic signed [15:0] out_right_o,
  output logic signed [15:0] out_bottom_o,
  output logic [8:0]  held_count_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_READ     = 3'd5;
  localparam logic [2:0] S_READ_RD  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [1:0] op_q, op_d;
  rrlt_pkg::rect_t query_q, query_d;
  logic done_q, done_d;
  logic [2:0] status_q, status_d;
  rrlt_pkg::rect_t out_q, out_d;

  rrlt_pkg::rect_t req_rect, rdata, wdata;
  rrlt_pkg::cmp_t  cmp;
  logic we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] ptr_p1, ptr_m1;
  logic req_valid, last, full;

  assign req_rect.left   = rect_left_i;
  assign req_rect.top    = rect_top_i;
  assign req_rect.right  = rect_right_i;
  assign req_rect.bottom = rect_bottom_i;

  assign req_valid = (rect_left_i < rect_right_i) && (rect_top_i < rect_bottom_i);
  assign ptr_p1 = ptr_q + CW'(1);
  assign ptr_m1 = ptr_q - CW'(1);
  assign last = (ptr_p1 >= count_q);
  assign full = (count_q >= CW'(ENTRIES));

  rrlt_store #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(rdata)
  );

  rrlt_cmp u_cmp (
    .a_i  (query_q),
    .b_i  (rdata),
    .res_o(cmp)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    op_d     = op_q;
    query_d  = query_q;
    done_d   = 1'b0;
    status_d = status_q;
    out_d    = out_q;
    we       = 1'b0;
    waddr    = count_q[AW-1:0];
    wdata    = query_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          query_d = req_rect;
          ptr_d   = '0;
          out_d   = '0;
          unique case (op_i)
            rrlt_pkg::OP_ACQUIRE, rrlt_pkg::OP_RELEASE: begin
              if (!req_valid) begin
                status_d = rrlt_pkg::ST_INVALID;
                done_d   = 1'b1;
              end else if (count_q == '0) begin
                if (op_i == rrlt_pkg::OP_ACQUIRE) begin
                  we       = 1'b1;
                  wdata    = req_rect;
                  count_d  = count_q + CW'(1);
                  status_d = rrlt_pkg::ST_OK;
                end else begin
                  status_d = rrlt_pkg::ST_NOTLOCKED;
                end
                done_d = 1'b1;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            rrlt_pkg::OP_CLEAR: begin
              count_d  = '0;
              status_d = rrlt_pkg::ST_OK;
              done_d   = 1'b1;
            end
            default: begin
              if ({1'b0, entry_index_i} >= 9'(count_q)) begin
                status_d = rrlt_pkg::ST_BADINDEX;
                done_d   = 1'b1;
              end else begin
                ptr_d   = CW'(entry_index_i);
                state_d = S_READ_RD;
              end
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (op_q == rrlt_pkg::OP_ACQUIRE) begin
          if (cmp.overlap) begin
            status_d = rrlt_pkg::ST_BUSY;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else if (last) begin
            if (full) begin
              status_d = rrlt_pkg::ST_FULL;
            end else begin
              we       = 1'b1;
              count_d  = count_q + CW'(1);
              status_d = rrlt_pkg::ST_OK;
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_p1;
            state_d = S_SCAN_RD;
          end
        end else begin
          if (cmp.equal) begin
            if (last) begin
              count_d  = count_q - CW'(1);
              status_d = rrlt_pkg::ST_OK;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              ptr_d   = ptr_p1;
              state_d = S_SHIFT_RD;
            end
          end else if (last) begin
            status_d = rrlt_pkg::ST_NOTLOCKED;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            ptr_d   = ptr_p1;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = ptr_m1[AW-1:0];
        wdata = rdata;
        if (last) begin
          count_d  = count_q - CW'(1);
          status_d = rrlt_pkg::ST_OK;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          ptr_d   = ptr_p1;
          state_d = S_SHIFT_RD;
        end
      end
      S_READ_RD: begin
        state_d = S_READ;
      end
      S_READ: begin
        out_d    = rdata;
        status_d = rrlt_pkg::ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    op_q     <= op_d;
    query_q  <= query_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_left_o   = out_q.left;
  assign out_top_o    = out_q.top;
  assign out_right_o  = out_q.right;
  assign out_bottom_o = out_q.bottom;
  assign held_count_o = 9'(count_q);

endmodule
